// File: design/ltcp_pkg.sv
`timescale 1ns / 1ps

package ltcp_pkg;

  localparam int unsigned FracBitsDefault = 16;

  // Matrix and field geometry
  localparam int unsigned CoefCount = 12;
  localparam int unsigned CoefIdxW  = 4;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned VpW       = 13;
  localparam int unsigned HalfW     = VpW - 1;
  localparam int unsigned PixW      = 16;
  localparam int unsigned ColorW    = 8;

  // Register port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [VpW-1:0] VpWidthReset  = 13'd640;
  localparam logic [VpW-1:0] VpHeightReset = 13'd480;

  typedef enum logic {
    ActLoad    = 1'b0,
    ActSegment = 1'b1
  } action_e;

  typedef enum logic {
    RegVpWidth  = 1'b0,
    RegVpHeight = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t              a;
    vec_t              b;
    logic [ColorW-1:0] red;
  } seg_t;

endpackage

// File: design/ltcp_xform.sv
`timescale 1ns / 1ps

module ltcp_xform
  import ltcp_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [CoefIdxW-1:0]      coef_index_i,
  input  logic signed [CoordW-1:0] coef_value_i,
  input  vec_t                     start_i,
  input  vec_t                     end_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output seg_t                     seg_o
);

  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned YW     = CoordW + 2;
  localparam int unsigned YProdW = YW + ColorW;
  localparam logic signed [YW-1:0]     TwoOne   = YW'(2) << FracBits;
  localparam logic signed [YProdW-1:0] ColorMax = YProdW'(255);
  localparam logic signed [SumW-1:0]   SatHi    = SumW'(2**(CoordW-1) - 1);
  localparam logic signed [SumW-1:0]   SatLo    = -SatHi - SumW'(1);

  logic signed [CoordW-1:0] mat_q [CoefCount];
  logic                     accept;
  logic                     en1, en2;
  logic                     v1_q, v2_q;
  logic signed [ProdW-1:0]  prod_q [2][3][3];
  logic signed [CoordW-1:0] off_q [3];
  logic [ColorW-1:0]        red1_q;
  logic signed [CoordW-1:0] pnt [2][3];
  logic signed [YW-1:0]     ysum;
  logic signed [YProdW-1:0] yprod;
  logic signed [YProdW-1:0] ysh;
  logic [ColorW-1:0]        red_d;
  logic signed [SumW-1:0]   acc;
  logic signed [CoordW-1:0] res [2][3];
  seg_t                     seg_d, seg_q;

  // Stage enables: a stage loads when empty or when it drains
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  // Coefficient loads take effect for the next transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CoefCount; i++) mat_q[i] <= '0;
    end else if (accept && action_i == ActLoad) begin
      for (int i = 0; i < CoefCount; i++) begin
        if (coef_index_i == CoefIdxW'(i)) mat_q[i] <= coef_value_i;
      end
    end
  end

  always_comb begin
    pnt[0][0] = start_i.x;
    pnt[0][1] = start_i.y;
    pnt[0][2] = start_i.z;
    pnt[1][0] = end_i.x;
    pnt[1][1] = end_i.y;
    pnt[1][2] = end_i.z;
  end

  // Pen color from the untransformed start y
  always_comb begin
    ysum  = YW'(start_i.y) + TwoOne;
    yprod = YProdW'(ysum) * ColorMax;
    ysh   = yprod >>> (FracBits + 2);
    if (ysh < 0) begin
      red_d = '0;
    end else if (ysh > ColorMax) begin
      red_d = ColorMax[ColorW-1:0];
    end else begin
      red_d = ysh[ColorW-1:0];
    end
  end

  // Stage 1: all nine products per endpoint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i && action_i == ActSegment;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int e = 0; e < 2; e++) begin
        for (int r = 0; r < 3; r++) begin
          for (int i = 0; i < 3; i++) begin
            prod_q[e][r][i] <= ProdW'(mat_q[r*4+i]) * ProdW'(pnt[e][i]);
          end
        end
      end
      for (int r = 0; r < 3; r++) off_q[r] <= mat_q[r*4+3];
      red1_q <= red_d;
    end
  end

  // Stage 2: sum, drop fraction, add translation, saturate
  always_comb begin
    acc = '0;
    for (int e = 0; e < 2; e++) begin
      for (int r = 0; r < 3; r++) begin
        acc = SumW'(prod_q[e][r][0]) + SumW'(prod_q[e][r][1]) + SumW'(prod_q[e][r][2]);
        acc = (acc >>> FracBits) + SumW'(off_q[r]);
        if (acc > SatHi) begin
          res[e][r] = SatHi[CoordW-1:0];
        end else if (acc < SatLo) begin
          res[e][r] = SatLo[CoordW-1:0];
        end else begin
          res[e][r] = acc[CoordW-1:0];
        end
      end
    end
    seg_d.a.x = res[0][0];
    seg_d.a.y = res[0][1];
    seg_d.a.z = res[0][2];
    seg_d.b.x = res[1][0];
    seg_d.b.y = res[1][1];
    seg_d.b.z = res[1][2];
    seg_d.red = red1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) seg_q <= seg_d;
  end

  assign out_valid_o = v2_q;
  assign seg_o       = seg_q;

endmodule

// File: design/ltcp_clip.sv
`timescale 1ns / 1ps

module ltcp_clip
  import ltcp_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  seg_t seg_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output seg_t seg_o
);

  localparam int unsigned DivW   = CoordW + 2;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned MulW   = DiffW + FracBits + 1;
  localparam int unsigned Steps  = FracBits;
  localparam int unsigned Stages = Steps + 3;
  localparam logic signed [CoordW-1:0] Near = CoordW'(0) - (CoordW'(2) << FracBits);

  typedef struct packed {
    vec_t                far_pt;
    vec_t                cls_pt;
    logic                clip;
    logic                far_is_a;
    logic [DivW-1:0]     rem;
    logic [DivW-1:0]     den;
    logic [FracBits-1:0] ratio;
    logic [ColorW-1:0]   red;
  } div_t;

  typedef struct packed {
    vec_t                   far_pt;
    vec_t                   cls_pt;
    logic                   clip;
    logic                   far_is_a;
    logic signed [MulW-1:0] dx;
    logic signed [MulW-1:0] dy;
    logic [ColorW-1:0]      red;
  } mul_t;

  logic [Stages:0]          en;
  logic [Stages-1:0]        v_q, v_in;
  logic                     fa, fb, ent_v;
  div_t                     ent;
  div_t                     div_q [Steps+1];
  div_t                     last;
  mul_t                     mul_d, mul_q;
  logic signed [CoordW-1:0] fx, fy;
  vec_t                     moved;
  seg_t                     out_d, out_q;

  // Enable chain, one bit per stage
  assign en[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign in_ready_o = en[0];

  // Entry: classify endpoints, drop culled segments, set up the ratio division
  always_comb begin
    fa           = seg_i.a.z <= Near;
    fb           = seg_i.b.z <= Near;
    ent.far_pt   = fa ? seg_i.a : seg_i.b;
    ent.cls_pt   = fa ? seg_i.b : seg_i.a;
    ent.clip     = fa ^ fb;
    ent.far_is_a = fa;
    ent.rem      = DivW'(Near) - DivW'(ent.far_pt.z);
    ent.den      = DivW'(ent.cls_pt.z) - DivW'(ent.far_pt.z);
    ent.ratio    = '0;
    ent.red      = seg_i.red;
    ent_v        = in_valid_i && !(fa && fb);
  end

  assign v_in = {v_q[Stages-2:0], ent_v};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) div_q[0] <= ent;
  end

  // Restoring division, one ratio bit per stage
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [DivW-1:0] dbl;
    div_t            step_d;

    always_comb begin
      dbl    = {div_q[k].rem[DivW-2:0], 1'b0};
      step_d = div_q[k];
      if (dbl >= div_q[k].den) begin
        step_d.rem   = dbl - div_q[k].den;
        step_d.ratio = {div_q[k].ratio[FracBits-2:0], 1'b1};
      end else begin
        step_d.rem   = dbl;
        step_d.ratio = {div_q[k].ratio[FracBits-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k+1]) div_q[k+1] <= step_d;
    end
  end

  // Scale the endpoint deltas by the ratio
  always_comb begin
    last           = div_q[Steps];
    mul_d.far_pt   = last.far_pt;
    mul_d.cls_pt   = last.cls_pt;
    mul_d.clip     = last.clip;
    mul_d.far_is_a = last.far_is_a;
    mul_d.red      = last.red;
    mul_d.dx = MulW'(DiffW'(last.cls_pt.x) - DiffW'(last.far_pt.x))
             * MulW'($signed({1'b0, last.ratio}));
    mul_d.dy = MulW'(DiffW'(last.cls_pt.y) - DiffW'(last.far_pt.y))
             * MulW'($signed({1'b0, last.ratio}));
  end

  always_ff @(posedge clk_i) begin
    if (en[Steps+1]) mul_q <= mul_d;
  end

  // Move the far endpoint onto the near plane and restore endpoint order
  always_comb begin
    fx    = mul_q.far_pt.x + CoordW'(mul_q.dx >>> FracBits);
    fy    = mul_q.far_pt.y + CoordW'(mul_q.dy >>> FracBits);
    moved = mul_q.far_pt;
    if (mul_q.clip) begin
      moved.x = fx;
      moved.y = fy;
      moved.z = Near;
    end
    out_d.red = mul_q.red;
    if (mul_q.far_is_a) begin
      out_d.a = moved;
      out_d.b = mul_q.cls_pt;
    end else begin
      out_d.a = mul_q.cls_pt;
      out_d.b = moved;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Steps+2]) out_q <= out_d;
  end

  assign out_valid_o = v_q[Stages-1];
  assign seg_o       = out_q;

endmodule

// File: design/ltcp_proj.sv
`timescale 1ns / 1ps

module ltcp_proj
  import ltcp_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  seg_t                   seg_i,
  input  logic [HalfW-1:0]       half_w_i,
  input  logic [HalfW-1:0]       half_h_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [PixW-1:0] screen_x0_o,
  output logic signed [PixW-1:0] screen_y0_o,
  output logic signed [PixW-1:0] screen_x1_o,
  output logic signed [PixW-1:0] screen_y1_o,
  output logic [ColorW-1:0]      pen_red_o,
  output logic [ColorW-1:0]      pen_green_o,
  output logic [ColorW-1:0]      pen_blue_o
);

  localparam int unsigned QBits  = PixW + 1;
  localparam int unsigned NumW   = CoordW + HalfW + 1;
  localparam int unsigned MagW   = NumW - 1;
  localparam int unsigned WW     = CoordW - 1;
  localparam int unsigned SumW   = QBits + 3;
  localparam int unsigned Stages = QBits + 3;
  localparam logic signed [CoordW-1:0] One     = CoordW'(1) << FracBits;
  localparam logic signed [PixW-1:0]   PixMax  = {1'b0, {(PixW-1){1'b1}}};
  localparam logic signed [PixW-1:0]   PixMin  = {1'b1, {(PixW-1){1'b0}}};
  localparam logic signed [SumW-1:0]   SumMax  = SumW'(PixMax);
  localparam logic signed [SumW-1:0]   SumMin  = SumW'(PixMin);

  typedef struct packed {
    logic signed [NumW-1:0] num;
    logic [WW-1:0]          w;
  } scl_t;

  typedef struct packed {
    logic             neg;
    logic             nz;
    logic             wz;
    logic             ovf;
    logic [WW-1:0]    w;
    logic [WW-1:0]    rem;
    logic [QBits-1:0] low;
    logic [QBits-1:0] quo;
  } crd_t;

  typedef struct packed {
    crd_t [3:0]        c;
    logic [ColorW-1:0] red;
  } pst_t;

  logic [Stages:0]          en;
  logic [Stages-1:0]        v_q, v_in;
  logic signed [CoordW-1:0] wa, wb;
  scl_t [3:0]               scl_d, scl_q;
  logic [ColorW-1:0]        red0_q;
  logic signed [NumW-1:0]   nn;
  logic [MagW-1:0]          mag;
  pst_t                     ent;
  pst_t                     div_q [QBits+1];
  pst_t                     last;
  logic [HalfW-1:0]         off;
  logic signed [SumW-1:0]   qs, sv;
  logic signed [PixW-1:0]   pix_d [4];
  logic signed [PixW-1:0]   pix_q [4];
  logic [ColorW-1:0]        red_q;

  assign en[Stages] = out_ready_i;
  for (genvar k = 0; k < Stages; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign in_ready_o = en[0];

  assign v_in = {v_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // Stage 0: perspective divisor and scaled numerators
  always_comb begin
    wa = (seg_i.a.z >>> 1) + One;
    wb = (seg_i.b.z >>> 1) + One;
    scl_d[0].num = NumW'($signed({1'b0, half_w_i})) * NumW'(seg_i.a.x);
    scl_d[1].num = NumW'($signed({1'b0, half_h_i})) * NumW'(seg_i.a.y);
    scl_d[2].num = NumW'($signed({1'b0, half_w_i})) * NumW'(seg_i.b.x);
    scl_d[3].num = NumW'($signed({1'b0, half_h_i})) * NumW'(seg_i.b.y);
    scl_d[0].w   = wa[WW-1:0];
    scl_d[1].w   = wa[WW-1:0];
    scl_d[2].w   = wb[WW-1:0];
    scl_d[3].w   = wb[WW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      scl_q  <= scl_d;
      red0_q <= seg_i.red;
    end
  end

  // Stage 1: flip y, take magnitudes, flag zero divisor and quotient overflow
  always_comb begin
    nn  = '0;
    mag = '0;
    for (int j = 0; j < 4; j++) begin
      nn  = ((j & 1) != 0) ? -scl_q[j].num : scl_q[j].num;
      mag = nn[NumW-1] ? MagW'(-nn) : MagW'(nn);
      ent.c[j].neg = nn[NumW-1];
      ent.c[j].nz  = nn != '0;
      ent.c[j].w   = scl_q[j].w;
      ent.c[j].wz  = scl_q[j].w == '0;
      ent.c[j].ovf = WW'(mag[MagW-1:QBits]) >= scl_q[j].w;
      ent.c[j].rem = WW'(mag[MagW-1:QBits]);
      ent.c[j].low = mag[QBits-1:0];
      ent.c[j].quo = '0;
    end
    ent.red = red0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) div_q[0] <= ent;
  end

  // Restoring division of the magnitude, one quotient bit per stage
  for (genvar k = 0; k < QBits; k++) begin : g_step
    logic [WW:0] dbl;
    pst_t        step_d;

    always_comb begin
      dbl    = '0;
      step_d = div_q[k];
      for (int j = 0; j < 4; j++) begin
        dbl = {div_q[k].c[j].rem, div_q[k].c[j].low[QBits-1-k]};
        if (dbl >= {1'b0, div_q[k].c[j].w}) begin
          step_d.c[j].rem = WW'(dbl - {1'b0, div_q[k].c[j].w});
          step_d.c[j].quo = {div_q[k].c[j].quo[QBits-2:0], 1'b1};
        end else begin
          step_d.c[j].rem = WW'(dbl);
          step_d.c[j].quo = {div_q[k].c[j].quo[QBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k+2]) div_q[k+1] <= step_d;
    end
  end

  // Final stage: floor, offset, saturate
  always_comb begin
    last = div_q[QBits];
    off  = '0;
    qs   = '0;
    sv   = '0;
    for (int j = 0; j < 4; j++) begin
      off = ((j & 1) != 0) ? half_h_i : half_w_i;
      if (last.c[j].neg) begin
        qs = -SumW'(last.c[j].quo) - SumW'(last.c[j].rem != '0);
      end else begin
        qs = SumW'(last.c[j].quo);
      end
      sv = qs + SumW'(off);
      if (last.c[j].wz) begin
        if (!last.c[j].nz) begin
          pix_d[j] = PixW'(off);
        end else begin
          pix_d[j] = last.c[j].neg ? PixMin : PixMax;
        end
      end else if (last.c[j].ovf) begin
        pix_d[j] = last.c[j].neg ? PixMin : PixMax;
      end else if (sv > SumMax) begin
        pix_d[j] = PixMax;
      end else if (sv < SumMin) begin
        pix_d[j] = PixMin;
      end else begin
        pix_d[j] = sv[PixW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Stages-1]) begin
      for (int j = 0; j < 4; j++) pix_q[j] <= pix_d[j];
      red_q <= last.red;
    end
  end

  assign out_valid_o = v_q[Stages-1];
  assign screen_x0_o = pix_q[0];
  assign screen_y0_o = pix_q[1];
  assign screen_x1_o = pix_q[2];
  assign screen_y1_o = pix_q[3];
  assign pen_red_o   = red_q;
  assign pen_green_o = {ColorW{1'b1}} - red_q;
  assign pen_blue_o  = {ColorW{1'b1}} - red_q;

endmodule

// File: design/line_transform_clip_project.sv
`timescale 1ns / 1ps

// Line segment transform, near-plane clip and screen projection. Each segment
// transfer runs through a pipeline of two stages of matrix transform,
// FracBits + 3 stages of near-plane clip whose length is set by the
// one-bit-per-stage clip ratio divider, and 20 stages of projection set by
// the 17-step perspective divider. A new transfer is taken every cycle; a
// stalled output only holds the pipeline once every stage behind it is full.
// Coefficient loads and culled segments produce no result. Coefficient loads
// apply to all segment transfers that follow them. The user must write the
// viewport registers through the register port only while no segment is in
// flight; the block itself does not enforce this.

module line_transform_clip_project
  import ltcp_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAddrW-1:0]      paddr,
  input  logic [ApbDataW-1:0]      pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready,
  // Input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [CoefIdxW-1:0]      coef_index_i,
  input  logic signed [CoordW-1:0] coef_value_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] start_z_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic signed [CoordW-1:0] end_z_i,
  // Output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PixW-1:0]   screen_x0_o,
  output logic signed [PixW-1:0]   screen_y0_o,
  output logic signed [PixW-1:0]   screen_x1_o,
  output logic signed [PixW-1:0]   screen_y1_o,
  output logic [ColorW-1:0]        pen_red_o,
  output logic [ColorW-1:0]        pen_green_o,
  output logic [ColorW-1:0]        pen_blue_o
);

  logic [VpW-1:0] vp_width_q, vp_height_q;
  vec_t           start_v, end_v;
  logic           xf_ready, xf_valid;
  seg_t           xf_seg;
  logic           cl_ready, cl_valid;
  seg_t           cl_seg;
  logic           pr_ready;

  // Viewport registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_width_q  <= VpWidthReset;
      vp_height_q <= VpHeightReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[2]))
        RegVpWidth:  vp_width_q  <= pwdata[VpW-1:0];
        RegVpHeight: vp_height_q <= pwdata[VpW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      RegVpWidth:  prdata = ApbDataW'(vp_width_q);
      RegVpHeight: prdata = ApbDataW'(vp_height_q);
    endcase
  end

  assign pready = 1'b1;

  always_comb begin
    start_v.x = start_x_i;
    start_v.y = start_y_i;
    start_v.z = start_z_i;
    end_v.x   = end_x_i;
    end_v.y   = end_y_i;
    end_v.z   = end_z_i;
  end

  assign in_stall_o = !xf_ready;

  ltcp_xform #(
    .FracBits (FracBits)
  ) u_xform (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (xf_ready),
    .action_i     (action_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .start_i      (start_v),
    .end_i        (end_v),
    .out_valid_o  (xf_valid),
    .out_ready_i  (cl_ready),
    .seg_o        (xf_seg)
  );

  ltcp_clip #(
    .FracBits (FracBits)
  ) u_clip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (xf_valid),
    .in_ready_o  (cl_ready),
    .seg_i       (xf_seg),
    .out_valid_o (cl_valid),
    .out_ready_i (pr_ready),
    .seg_o       (cl_seg)
  );

  ltcp_proj #(
    .FracBits (FracBits)
  ) u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cl_valid),
    .in_ready_o  (pr_ready),
    .seg_i       (cl_seg),
    .half_w_i    (vp_width_q[VpW-1:1]),
    .half_h_i    (vp_height_q[VpW-1:1]),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .screen_x0_o (screen_x0_o),
    .screen_y0_o (screen_y0_o),
    .screen_x1_o (screen_x1_o),
    .screen_y1_o (screen_y1_o),
    .pen_red_o   (pen_red_o),
    .pen_green_o (pen_green_o),
    .pen_blue_o  (pen_blue_o)
  );

endmodule

// File: sim/segment_projection_checker.sv
`timescale 1ns / 1ps

module segment_projection_checker
  import ltcp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAddrW-1:0]      paddr,
  input  logic [ApbDataW-1:0]      pwdata,
  input  logic                     pready,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     action_i,
  input  logic [CoefIdxW-1:0]      coef_index_i,
  input  logic signed [CoordW-1:0] coef_value_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] start_z_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic signed [CoordW-1:0] end_z_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [PixW-1:0]   screen_x0_i,
  input  logic signed [PixW-1:0]   screen_y0_i,
  input  logic signed [PixW-1:0]   screen_x1_i,
  input  logic signed [PixW-1:0]   screen_y1_i,
  input  logic [ColorW-1:0]        pen_red_i,
  input  logic [ColorW-1:0]        pen_green_i,
  input  logic [ColorW-1:0]        pen_blue_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam int  Frac = FracBitsDefault;
  localparam longint One = longint'(1) << Frac;
  localparam longint NearZ = -2 * One;

  typedef struct packed {
    logic signed [PixW-1:0] x0;
    logic signed [PixW-1:0] y0;
    logic signed [PixW-1:0] x1;
    logic signed [PixW-1:0] y1;
    logic [ColorW-1:0]      red;
    logic [ColorW-1:0]      green;
    logic [ColorW-1:0]      blue;
  } screen_seg_t;

  longint      model_coef [CoefCount];
  longint      vp_width;
  longint      vp_height;
  screen_seg_t pending_screens [$];

  assign pending_o = pending_screens.size();

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Exact floor((m0*x + m1*y + m2*z) / 2^F) + m3, saturated to 32 bits, split to avoid overflow
  function automatic longint transform_row(int row, longint px, longint py, longint pz);
    longint          p [3];
    longint          prod;
    longint          hi;
    longint unsigned lo;
    p[0] = px; p[1] = py; p[2] = pz;
    hi = 0;
    lo = 0;
    for (int i = 0; i < 3; i++) begin
      prod = model_coef[row*4+i] * p[i];
      hi += prod >>> Frac;
      lo += longint'(prod) & (One - 1);
    end
    hi += longint'(lo >> Frac) + model_coef[row*4+3];
    return clamp(hi, -(longint'(1) << 31), (longint'(1) << 31) - 1);
  endfunction

  function automatic logic [PixW-1:0] to_pixel(longint scale, longint c, longint w,
                                               longint offset);
    longint n;
    longint q;
    n = scale * c;
    if (w == 0) begin
      if (n > 0) return 16'sd32767;
      if (n < 0) return -16'sd32768;
      return PixW'(clamp(offset, -32768, 32767));
    end
    q = n / w;
    if (n < 0 && q * w != n) q--;
    return PixW'(clamp(q + offset, -32768, 32767));
  endfunction

  // Transform, clip to the near plane and project one segment
  function automatic logic project_segment(output screen_seg_t seg);
    longint a [3];
    longint b [3];
    longint far_p [3];
    longint cl_p [3];
    longint r, wa, wb, w2, h2, red;
    logic   fa, fb;
    a[0] = start_x_i; a[1] = start_y_i; a[2] = start_z_i;
    b[0] = end_x_i;   b[1] = end_y_i;   b[2] = end_z_i;
    for (int i = 0; i < 3; i++) begin
      far_p[i] = transform_row(i, a[0], a[1], a[2]);
      cl_p[i]  = transform_row(i, b[0], b[1], b[2]);
    end
    fa = far_p[2] <= NearZ;
    fb = cl_p[2] <= NearZ;
    seg = '0;
    if (fa && fb) return 1'b0;
    // far_p holds start, cl_p end; swap roles when the end is behind
    if (fa || fb) begin
      if (fb) begin
        for (int i = 0; i < 3; i++) begin
          r = far_p[i]; far_p[i] = cl_p[i]; cl_p[i] = r;
        end
      end
      r = ((NearZ - far_p[2]) * One) / (cl_p[2] - far_p[2]);
      for (int i = 0; i < 2; i++) far_p[i] += ((cl_p[i] - far_p[i]) * r) >>> Frac;
      far_p[2] = NearZ;
      if (fb) begin
        for (int i = 0; i < 3; i++) begin
          r = far_p[i]; far_p[i] = cl_p[i]; cl_p[i] = r;
        end
      end
    end
    w2 = vp_width / 2;
    h2 = vp_height / 2;
    wa = (far_p[2] >>> 1) + One;
    wb = (cl_p[2] >>> 1) + One;
    red = clamp((255 * (a[1] + 2 * One)) >>> (Frac + 2), 0, 255);
    seg.x0    = to_pixel(w2, far_p[0], wa, w2);
    seg.y0    = to_pixel(-h2, far_p[1], wa, h2);
    seg.x1    = to_pixel(w2, cl_p[0], wb, w2);
    seg.y1    = to_pixel(-h2, cl_p[1], wb, h2);
    seg.red   = ColorW'(red);
    seg.green = ColorW'(255 - red);
    seg.blue  = ColorW'(255 - red);
    return 1'b1;
  endfunction

  // Track registers and matrix, predict on input transfers, compare outputs
  always @(posedge clk_i or negedge rst_ni) begin
    screen_seg_t want;
    screen_seg_t got;
    if (!rst_ni) begin
      foreach (model_coef[i]) model_coef[i] = 0;
      vp_width  = VpWidthReset;
      vp_height = VpHeightReset;
      pending_screens.delete();
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegVpHeight) vp_height = pwdata & 32'h1FFF;
        else vp_width = pwdata & 32'h1FFF;
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{screen_x0_i, screen_y0_i, screen_x1_i, screen_y1_i,
                pen_red_i, pen_green_i, pen_blue_i};
        if (pending_screens.size() == 0) begin
          $display("%0t: unexpected transfer, actual %p", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_screens.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p actual %p", $realtime, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ActLoad) begin
          if (coef_index_i < CoefCount) model_coef[coef_index_i] = coef_value_i;
        end else if (project_segment(want)) begin
          pending_screens.insert(pending_screens.size(), want);
        end
      end
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ltcp_pkg::*;

  localparam int One = 1 << FracBitsDefault;

  logic                     clk, rst_n;
  logic                     psel, penable, pwrite;
  logic [ApbAddrW-1:0]      paddr;
  logic [ApbDataW-1:0]      pwdata, prdata;
  logic                     pready;
  logic                     in_valid, in_stall, action;
  logic [CoefIdxW-1:0]      coef_index;
  logic signed [CoordW-1:0] coef_value, sx, sy, sz, ex, ey, ez;
  logic                     out_valid, out_stall;
  logic signed [PixW-1:0]   x0, y0, x1, y1;
  logic [ColorW-1:0]        red, green, blue;
  int unsigned              fail_count, pending;
  int                       burst_left;

  line_transform_clip_project u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .action_i(action),
    .coef_index_i(coef_index), .coef_value_i(coef_value),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .screen_x0_o(x0), .screen_y0_o(y0), .screen_x1_o(x1), .screen_y1_o(y1),
    .pen_red_o(red), .pen_green_o(green), .pen_blue_o(blue)
  );

  segment_projection_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .action_i(action),
    .coef_index_i(coef_index), .coef_value_i(coef_value),
    .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .end_x_i(ex), .end_y_i(ey), .end_z_i(ez),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .screen_x0_i(x0), .screen_y0_i(y0), .screen_x1_i(x1), .screen_y1_i(y1),
    .pen_red_i(red), .pen_green_i(green), .pen_blue_i(blue),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stall: switch between free, light, heavy and periodic stalling
  initial begin
    int mode;
    int cnt;
    out_stall = 1'b0;
    cnt = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cnt % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (cnt % 5 < 2);
      endcase
      cnt++;
    end
  end

  // Hold one transfer until accepted; bursts of random length, random gaps
  task automatic send(action_e act, int idx, int cv, int ax, int ay, int az,
                      int bx, int by, int bz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    action     <= act;
    coef_index <= idx[CoefIdxW-1:0];
    coef_value <= cv;
    sx <= ax; sy <= ay; sz <= az;
    ex <= bx; ey <= by; ez <= bz;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_coef(int idx, int value);
    send(ActLoad, idx, value, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom);
  endtask

  task automatic segment(int ax, int ay, int az, int bx, int by, int bz);
    send(ActSegment, $urandom, $urandom, ax, ay, az, bx, by, bz);
  endtask

  // Wait until every expected transfer has arrived and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e reg_sel, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(int'(reg_sel) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int coord();
    if ($urandom_range(0, 9) < 2) return $urandom;
    return int'($urandom_range(0, 16 * One)) - 8 * One;
  endfunction

  task automatic load_identity();
    for (int i = 0; i < CoefCount; i++)
      load_coef(i, (i == 0 || i == 5 || i == 10) ? One : 0);
  endtask

  initial begin
    int w_list [6];
    int h_list [6];
    w_list = '{640, 1, 4096, 0, 8191, 0};
    h_list = '{480, 1, 4096, 8191, 0, 0};
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; action = 1'b0; coef_index = '0; coef_value = '0;
    sx = '0; sy = '0; sz = '0; ex = '0; ey = '0; ez = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      // Reconfigure only while idle
      if (ph == 5) begin
        w_list[ph] = $urandom_range(1, 4096);
        h_list[ph] = $urandom_range(1, 4096);
      end
      write_reg(RegVpWidth, {$urandom} << 13 | w_list[ph]);
      write_reg(RegVpHeight, {$urandom} << 13 | h_list[ph]);

      if (ph == 0) begin
        // Directed: zero matrix, ignored indexes, extremes, clip and cull
        segment(One, One, One, -One, -One, -One);
        load_coef(12, One);
        load_coef(15, -1);
        load_identity();
        segment(0, 0, 0, One, One, One);
        segment(One, One, -3 * One, -One, One, -5 * One);
        segment(One, 2 * One, -4 * One, -One, -One, 0);
        segment(-One, One, 0, 3 * One, -2 * One, -4 * One);
        segment(One, -One, -2 * One + 1, -One, One, -2 * One + 1);
        segment(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
        segment(0, 2 * One, 0, 0, -2 * One, 0);
        segment(0, -2 * One - 1, 0, 0, 8 * One, 0);
        load_coef(3, 32'h7fffffff);
        load_coef(7, 32'h80000000);
        load_coef(1, 32'h80000000);
        segment(32'h7fffffff, 32'h80000000, One, One, One, One);
        load_identity();
      end else begin
        // Small matrix with z pushed mostly in front of the near plane
        for (int i = 0; i < CoefCount; i++)
          load_coef(i, (i == 11) ? int'($urandom_range(0, 4 * One)) - One
                                 : int'($urandom_range(0, 4 * One)) - 2 * One);
      end

      for (int n = 0; n < 320; n++) begin
        if (n == 160) drain();
        if ($urandom_range(0, 19) == 0)
          load_coef($urandom_range(0, 15), ($urandom_range(0, 3) == 0) ? $urandom
                    : int'($urandom_range(0, 4 * One)) - 2 * One);
        else
          segment(coord(), coord(), coord(), coord(), coord(), coord());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("status: fail");
    $finish;
  end

endmodule

// File: line_transform_clip_project.f
design/ltcp_pkg.sv
design/ltcp_xform.sv
design/ltcp_clip.sv
design/ltcp_proj.sv
design/line_transform_clip_project.sv
sim/segment_projection_checker.sv
sim/tb_top.sv
